@@ rtl/core/slot_presence_pending_queue_top_macros.svh @@
// assertion macros shared by the slot presence pending queue rtl
`ifndef SLOT_PRESENCE_PENDING_QUEUE_TOP_MACROS_SVH
`define SLOT_PRESENCE_PENDING_QUEUE_TOP_MACROS_SVH

// same-cycle implication, checked on clk and held off during rst
`define SPPQ_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on clk and held off during rst
`define SPPQ_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/sppq_pkg.sv @@
// shared constants, types and helpers of the slot presence pending queue
`default_nettype none

package sppq_pkg;

  localparam int SLOT_COUNT    = 20;
  localparam int PINS_PER_BANK = 5;
  localparam int RING_DEPTH    = 20;

  localparam int SLOT_W = 5;
  localparam int BANK_W = 2;
  localparam int EV_W   = 2;
  localparam int PIN_W  = (PINS_PER_BANK > 1) ? $clog2(PINS_PER_BANK) : 1;
  localparam int PTR_W  = $clog2(RING_DEPTH);

  localparam logic [EV_W-1:0] EV_INSERT = 2'd0;
  localparam logic [EV_W-1:0] EV_REMOVE = 2'd1;
  localparam logic [EV_W-1:0] EV_POP    = 2'd2;
  localparam logic [EV_W-1:0] EV_EMPTY  = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic pick;
    logic ins;
    logic rm_start;
    logic rm_miss;
    logic rd_scan;
    logic scan_adv;
    logic sh_rd;
    logic sh_wr;
    logic rm_done;
    logic rd_head;
    logic pop_done;
    logic pop_empty;
    logic emit;
  } sppq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_pop;
    logic in_any;
    logic cur_insert;
    logic ptr_at_tail;
    logic ptr_next_tail;
    logic hit;
    logic ring_empty;
    logic res_last;
    logic out_free;
  } sppq_sts_t;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(RING_DEPTH - 1)) r = '0;
    else r = p + PTR_W'(1);
    return r;
  endfunction

  function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == '0) r = PTR_W'(RING_DEPTH - 1);
    else r = p - PTR_W'(1);
    return r;
  endfunction

  // slot number of a pin in a bank, one bit wider so that out of range shows
  function automatic logic [SLOT_W:0] pin_slot(input logic [BANK_W-1:0] b,
                                               input logic [PIN_W-1:0] i);
    logic [SLOT_W:0] r;
    r = (SLOT_W+1)'(b) * (SLOT_W+1)'(PINS_PER_BANK) + (SLOT_W+1)'(i);
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/sppq_ctrl.sv @@
// control state machine that sequences pin events, queue scans and pops
`default_nettype none

module sppq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire sppq_pkg::sppq_sts_t sts,
  output sppq_pkg::sppq_cmd_t    cmd
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_PICK     = 4'd1;
  localparam logic [3:0] ST_DO       = 4'd2;
  localparam logic [3:0] ST_SCAN_RD  = 4'd3;
  localparam logic [3:0] ST_SCAN_CMP = 4'd4;
  localparam logic [3:0] ST_SH_CHK   = 4'd5;
  localparam logic [3:0] ST_SH_WR    = 4'd6;
  localparam logic [3:0] ST_POP_CHK  = 4'd7;
  localparam logic [3:0] ST_POP_WAIT = 4'd8;
  localparam logic [3:0] ST_EMIT     = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load = 1'b1;
          if (sts.in_pop) state_next = ST_POP_CHK;
          else if (sts.in_any) state_next = ST_PICK;
        end
      end
      ST_PICK: begin
        cmd.pick   = 1'b1;
        state_next = ST_DO;
      end
      ST_DO: begin
        if (sts.cur_insert) begin
          cmd.ins    = 1'b1;
          state_next = ST_EMIT;
        end else begin
          cmd.rm_start = 1'b1;
          if (sts.ptr_at_tail) begin
            cmd.rm_miss = 1'b1;
            state_next  = ST_EMIT;
          end else begin
            state_next = ST_SCAN_RD;
          end
        end
      end
      ST_SCAN_RD: begin
        cmd.rd_scan = 1'b1;
        state_next  = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        if (sts.hit) begin
          state_next = ST_SH_CHK;
        end else begin
          cmd.scan_adv = 1'b1;
          if (sts.ptr_next_tail) begin
            cmd.rm_miss = 1'b1;
            state_next  = ST_EMIT;
          end else begin
            state_next = ST_SCAN_RD;
          end
        end
      end
      ST_SH_CHK: begin
        if (sts.ptr_next_tail) begin
          cmd.rm_done = 1'b1;
          state_next  = ST_EMIT;
        end else begin
          cmd.sh_rd  = 1'b1;
          state_next = ST_SH_WR;
        end
      end
      ST_SH_WR: begin
        cmd.sh_wr  = 1'b1;
        state_next = ST_SH_CHK;
      end
      ST_POP_CHK: begin
        if (sts.ring_empty) begin
          cmd.pop_empty = 1'b1;
          state_next    = ST_EMIT;
        end else begin
          cmd.rd_head = 1'b1;
          state_next  = ST_POP_WAIT;
        end
      end
      ST_POP_WAIT: begin
        cmd.pop_done = 1'b1;
        state_next   = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = sts.res_last ? ST_IDLE : ST_PICK;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/sppq_datapath.sv @@
// presence bits, pending ring memory, pointers and output register
`default_nettype none
`include "slot_presence_pending_queue_top_macros.svh"

module sppq_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_kind,
  input  wire logic [sppq_pkg::BANK_W-1:0]     in_bank,
  input  wire logic [sppq_pkg::PINS_PER_BANK-1:0] in_flags,
  input  wire logic [sppq_pkg::PINS_PER_BANK-1:0] in_levels,
  input  wire sppq_pkg::sppq_cmd_t             cmd,
  output sppq_pkg::sppq_sts_t                  sts,
  input  wire logic                            m_tready,
  output logic                                 out_valid,
  output logic [sppq_pkg::EV_W-1:0]            out_event,
  output logic [sppq_pkg::SLOT_W-1:0]          out_slot,
  output logic                                 out_dropped,
  output logic                                 out_pending,
  output logic                                 out_last
);

  localparam int PINS = sppq_pkg::PINS_PER_BANK;

  logic [sppq_pkg::SLOT_COUNT-1:0]     present;
  logic [sppq_pkg::SLOT_W-1:0]         ring [sppq_pkg::RING_DEPTH];
  logic [sppq_pkg::SLOT_W-1:0]         rdata;
  logic [sppq_pkg::PTR_W-1:0]          head;
  logic [sppq_pkg::PTR_W-1:0]          tail;
  logic [sppq_pkg::PTR_W-1:0]          ptr;
  logic [sppq_pkg::BANK_W-1:0]         bank_r;
  logic [PINS-1:0]                     levels_r;
  logic [PINS-1:0]                     mask;
  logic [sppq_pkg::SLOT_W-1:0]         slot_r;
  logic                                cur_level;
  logic                                last_r;

  logic [sppq_pkg::EV_W-1:0]           res_ev;
  logic [sppq_pkg::SLOT_W-1:0]         res_slot;
  logic                                res_drop;
  logic                                res_pend;
  logic                                res_last;

  logic [PINS-1:0]                     mask_in;
  logic [sppq_pkg::SLOT_W:0]           qslot;
  logic [sppq_pkg::PIN_W-1:0]          pick_idx;
  logic [sppq_pkg::SLOT_W:0]           pick_wide;
  logic [PINS-1:0]                     mask_left;
  logic                                full;
  logic                                we;
  logic [sppq_pkg::PTR_W-1:0]          wa;
  logic [sppq_pkg::SLOT_W-1:0]         wd;
  logic [sppq_pkg::PTR_W-1:0]          ra;

  // flagged pins whose level differs from the slot's presence, known up front
  always_comb begin
    mask_in = '0;
    qslot   = '0;
    for (int i = 0; i < PINS; i++) begin
      qslot = sppq_pkg::pin_slot(in_bank, sppq_pkg::PIN_W'(i));
      if (in_flags[i] && (qslot < (sppq_pkg::SLOT_W+1)'(sppq_pkg::SLOT_COUNT))) begin
        mask_in[i] = (in_levels[i] != present[qslot[sppq_pkg::SLOT_W-1:0]]);
      end
    end
  end

  // lowest pending pin
  always_comb begin
    pick_idx = '0;
    for (int i = PINS - 1; i >= 0; i--) begin
      if (mask[i]) pick_idx = sppq_pkg::PIN_W'(i);
    end
  end

  assign pick_wide = sppq_pkg::pin_slot(bank_r, pick_idx);
  assign mask_left = mask & ~(PINS'(1) << pick_idx);
  assign full      = (sppq_pkg::ring_next(tail) == head);

  always_comb begin
    we = 1'b0;
    wa = tail;
    wd = slot_r;
    if (cmd.ins && !full) begin
      we = 1'b1;
    end else if (cmd.sh_wr) begin
      we = 1'b1;
      wa = ptr;
      wd = rdata;
    end
  end

  always_comb begin
    ra = ptr;
    if (cmd.sh_rd) ra = sppq_pkg::ring_next(ptr);
    else if (cmd.rd_head) ra = head;
  end

  always_ff @(posedge clk) begin
    if (we) ring[wa] <= wd;
    rdata <= ring[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present   <= '0;
      head      <= '0;
      tail      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.ins) begin
        present[slot_r] <= 1'b1;
        if (!full) tail <= sppq_pkg::ring_next(tail);
      end
      if (cmd.rm_start) present[slot_r] <= 1'b0;
      if (cmd.rm_done) tail <= sppq_pkg::ring_prev(tail);
      if (cmd.pop_done) head <= sppq_pkg::ring_next(head);
      if (cmd.emit) out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bank_r   <= in_bank;
      levels_r <= in_levels;
      mask     <= mask_in;
    end
    if (cmd.pick) begin
      slot_r    <= pick_wide[sppq_pkg::SLOT_W-1:0];
      cur_level <= levels_r[pick_idx];
      mask      <= mask_left;
      last_r    <= (mask_left == '0);
      ptr       <= head;
    end
    if (cmd.scan_adv || cmd.sh_wr) ptr <= sppq_pkg::ring_next(ptr);
    if (cmd.ins) begin
      res_ev   <= sppq_pkg::EV_INSERT;
      res_slot <= slot_r;
      res_drop <= full;
      res_pend <= 1'b0;
      res_last <= last_r;
    end
    if (cmd.rm_miss || cmd.rm_done) begin
      res_ev   <= sppq_pkg::EV_REMOVE;
      res_slot <= slot_r;
      res_drop <= 1'b0;
      res_pend <= cmd.rm_done;
      res_last <= last_r;
    end
    if (cmd.pop_empty) begin
      res_ev   <= sppq_pkg::EV_EMPTY;
      res_slot <= '0;
      res_drop <= 1'b0;
      res_pend <= 1'b0;
      res_last <= 1'b1;
    end
    if (cmd.pop_done) begin
      res_ev   <= sppq_pkg::EV_POP;
      res_slot <= rdata;
      res_drop <= 1'b0;
      res_pend <= 1'b0;
      res_last <= 1'b1;
    end
    if (cmd.emit) begin
      out_event   <= res_ev;
      out_slot    <= res_slot;
      out_dropped <= res_drop;
      out_pending <= res_pend;
      out_last    <= res_last;
    end
  end

  assign sts.in_pop        = in_kind;
  assign sts.in_any        = (mask_in != '0);
  assign sts.cur_insert    = cur_level;
  assign sts.ptr_at_tail   = (ptr == tail);
  assign sts.ptr_next_tail = (sppq_pkg::ring_next(ptr) == tail);
  assign sts.hit           = (rdata == slot_r);
  assign sts.ring_empty    = (head == tail);
  assign sts.res_last      = res_last;
  assign sts.out_free      = !out_valid || m_tready;

  `SPPQ_IMPLIES(a_emit_slot_free, cmd.emit, !out_valid || m_tready, "result overwrote unsent transfer")
  `SPPQ_NEXT(a_ins_tail, cmd.ins && !full, tail == sppq_pkg::ring_next($past(tail)), "tail not advanced on enqueue")
  `SPPQ_NEXT(a_rm_tail, cmd.rm_done, tail == sppq_pkg::ring_prev($past(tail)), "tail not stepped back on removal")
  `SPPQ_NEXT(a_pop_head, cmd.pop_done, (head == sppq_pkg::ring_next($past(head))) && (tail == $past(tail)), "pop moved wrong pointer")

endmodule

`default_nettype wire

@@ rtl/core/slot_presence_pending_queue_top.sv @@
// an insert event steps through pick, update and emit; a pop checks the ring, reads the head and emits,
// or emits without a read when the ring is empty; a remove event scans the ring from the head, and when
// found moves each later entry forward before it emits; one item at a time, the ring memory walk sets
// the rate; s_tready returns once the last result is in the output register
// reset clears presence, head, tail and the output valid; ring contents stay as they are
// top level: stream ports, controller and datapath
`default_nettype none

module slot_presence_pending_queue_top (
  input  wire logic        clk,
  input  wire logic        rst,
  // update or pop transfer
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // bank [1:0], change_flags [6:2], pin_levels [11:7], zero pad
  input  wire logic        s_tuser,   // kind: 0 pin update, 1 pop
  // result transfer
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // slot [4:0], dropped [5], was_pending [6], zero pad [7]
  output logic [1:0]       m_tuser,   // event_res
  output logic             m_tlast    // final result of the input item
);

  sppq_pkg::sppq_cmd_t cmd;
  sppq_pkg::sppq_sts_t sts;

  logic [sppq_pkg::SLOT_W-1:0] out_slot;
  logic                        out_dropped;
  logic                        out_pending;

  // sequencer: accepts an item in idle, then walks pins, ring scan and compaction, or a pop
  sppq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // presence bits, ring memory and the result register toward the master side
  sppq_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_kind     (s_tuser),
    .in_bank     (s_tdata[1:0]),
    .in_flags    (s_tdata[6:2]),
    .in_levels   (s_tdata[11:7]),
    .cmd         (cmd),
    .sts         (sts),
    .m_tready    (m_tready),
    .out_valid   (m_tvalid),
    .out_event   (m_tuser),
    .out_slot    (out_slot),
    .out_dropped (out_dropped),
    .out_pending (out_pending),
    .out_last    (m_tlast)
  );

  // pack result fields, lowest first
  assign m_tdata = {1'b0, out_pending, out_dropped, out_slot};

endmodule

`default_nettype wire
